[src/pfwd_pkg.sv]
// Package: constants, types and the result kind codes for the work dispatcher.
package pfwd_pkg;

    localparam int WORKERS    = 8;
    localparam int TASK_SLOTS = 128;
    localparam int WID_W      = 6;
    localparam int TID_W      = 7;
    localparam int CNT_W      = 31;
    localparam int WIDX_W     = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int SIDX_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DONE    = 2'd1,
        ACT_POLL    = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_INLINE = 2'd0,
        KIND_SLICE  = 2'd1,
        KIND_HANDLE = 2'd2,
        KIND_FINISH = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV1,
        ST_CLAIM,
        ST_SLOT,
        ST_SLOT_CHK,
        ST_DIV2,
        ST_EMIT,
        ST_HANDLE,
        ST_INLINE,
        ST_DONE_RD,
        ST_DONE_WR,
        ST_POLL_RD,
        ST_POLL_WR
    } state_t;

    // Divider control beat
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

endpackage

[src/parallel_for_work_dispatcher.sv]
// Top level: sequencer, worker and slot state of the work dispatcher.
//   channel   direction  handshake             payload
//   command   in         start & !busy         action item_count min_range worker_id task_id
//   result    out        result_valid strobe   kind worker_index slice_start slice_end
//                                              task_handle task_done last
//   config    in         cfg_we                cfg_wdata (active_workers)
// An enqueue keeps busy high through two passes of the shared divider, a worker scan of
// one worker a cycle (up to 8), a slot scan of one slot a cycle (up to 128), the slices
// and the handle; a full slot table runs inline instead. A disabled pool or an empty
// job runs inline with no divider pass; a worker-done and a finish poll each wait on the
// registered read of the slot count memory.
// Results leave at most one per cycle; the receiver cannot stall them.
// Reset clears busy bits, in-use bits and the register to 8; slot counts are
// rewritten at each claim, so no clearing pass is needed.
module parallel_for_work_dispatcher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [30:0] item_count,
    input  logic [30:0] min_range,
    input  logic [5:0]  worker_id,
    input  logic [6:0]  task_id,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    output logic        result_valid,
    output logic [1:0]  kind,
    output logic [5:0]  worker_index,
    output logic [30:0] slice_start,
    output logic [30:0] slice_end,
    output logic [6:0]  task_handle,
    output logic        task_done,
    output logic        last
);
    import pfwd_pkg::*;

    localparam int N_W = WIDX_W + 1;

    state_t              state_reg, state_next;
    logic [6:0]          active_reg;
    logic [WORKERS-1:0]  wbusy_reg, wbusy_next;
    logic [TID_W-1:0]    wtask_reg [WORKERS];
    logic [TASK_SLOTS-1:0] used_reg, used_next;
    logic [CNT_W-1:0]    items_reg, minr_reg;
    logic [WID_W-1:0]    wid_reg;
    logic [TID_W-1:0]    tid_reg;
    logic [N_W-1:0]      n_eff;
    logic [N_W-1:0]      wanted_reg, wanted_next;
    logic [N_W-1:0]      claimed_reg, claimed_next;
    logic [WORKERS-1:0]  picked_reg, picked_next;
    logic [N_W-1:0]      scan_reg, scan_next;
    logic [SIDX_W:0]     sscan_reg, sscan_next;
    logic [SIDX_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]    per_reg, per_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [N_W-1:0]      emitted_reg, emitted_next;
    div_req_t            dreq;
    logic                dbusy;
    logic [CNT_W-1:0]    quo;
    logic                ram_we;
    logic [SIDX_W-1:0]   ram_waddr, ram_raddr;
    logic [6:0]          ram_wdata, ram_rdata;
    logic                accept;
    logic                dwork;

    // Output beat registers
    logic        rv_reg, rv_next;
    logic [1:0]  kind_reg, kind_next;
    logic [5:0]  widx_reg, widx_next;
    logic [30:0] st_reg, st_next, en_reg, en_next;
    logic [6:0]  th_reg, th_next;
    logic        dn_reg, dn_next, last_reg, last_next;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign n_eff  = (active_reg > 7'(WORKERS)) ? N_W'(WORKERS) : N_W'(active_reg);
    assign dwork  = (wid_reg < WID_W'(WORKERS)) && wbusy_reg[wid_reg[WIDX_W-1:0]];

    pfwd_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .quotient(quo));

    pfwd_slot_ram u_ram (.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
                         .raddr(ram_raddr), .rdata(ram_rdata));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    case (action_t'(action))
                        ACT_ENQUEUE:
                            if (n_eff <= N_W'(1) || item_count == '0)
                                state_next = ST_INLINE;
                            else
                                state_next = ST_DIV1;
                        ACT_DONE: state_next = ST_DONE_RD;
                        ACT_POLL: state_next = ST_POLL_RD;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            ST_DIV1:     if (!dbusy) state_next = ST_CLAIM;
            ST_CLAIM:
                if (scan_reg >= n_eff || claimed_reg >= wanted_reg)
                    state_next = (claimed_reg == '0) ? ST_INLINE : ST_SLOT;
            ST_SLOT:
                if (sscan_reg >= (SIDX_W+1)'(TASK_SLOTS))
                    state_next = ST_INLINE;
                else if (!used_reg[sscan_reg[SIDX_W-1:0]])
                    state_next = ST_SLOT_CHK;
            ST_SLOT_CHK: state_next = ST_DIV2;
            ST_DIV2:     if (!dbusy) state_next = ST_EMIT;
            ST_EMIT:     if (emitted_next == claimed_reg) state_next = ST_HANDLE;
            ST_HANDLE:   state_next = ST_IDLE;
            ST_INLINE:   state_next = ST_IDLE;
            ST_DONE_RD:  state_next = ST_DONE_WR;
            ST_DONE_WR:  state_next = ST_IDLE;
            ST_POLL_RD:  state_next = ST_POLL_WR;
            ST_POLL_WR:  state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs per state
    always_comb
    begin
        wbusy_next   = wbusy_reg;
        used_next    = used_reg;
        wanted_next  = wanted_reg;
        claimed_next = claimed_reg;
        picked_next  = picked_reg;
        scan_next    = scan_reg;
        sscan_next   = sscan_reg;
        slot_next    = slot_reg;
        per_next     = per_reg;
        pos_next     = pos_reg;
        emitted_next = emitted_reg;
        dreq         = '0;
        ram_we       = 1'b0;
        ram_waddr    = slot_reg;
        ram_wdata    = 7'(claimed_reg);
        ram_raddr    = slot_reg;
        rv_next      = 1'b0;
        kind_next    = KIND_INLINE;
        widx_next    = '0;
        st_next      = '0;
        en_next      = '0;
        th_next      = '0;
        dn_next      = 1'b0;
        last_next    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                scan_next    = '0;
                sscan_next   = '0;
                claimed_next = '0;
                picked_next  = '0;
                emitted_next = '0;
                pos_next     = '0;
                // Start items/min_range; no cap gives quotient of all ones
                dreq.start    = accept && action_t'(action) == ACT_ENQUEUE;
                dreq.dividend = item_count;
                dreq.divisor  = min_range;
            end
            ST_DIV1:
                if (!dbusy)
                begin
                    wanted_next = n_eff;
                    if (minr_reg != '0 && CNT_W'(wanted_next) > quo)
                        wanted_next = N_W'(quo);
                    if (CNT_W'(wanted_next) > items_reg)
                        wanted_next = N_W'(items_reg);
                    if (wanted_next == '0)
                        wanted_next = N_W'(1);
                end
            ST_CLAIM:
                // Scan one worker a cycle, claiming it if idle
                if (!(scan_reg >= n_eff || claimed_reg >= wanted_reg))
                begin
                    if (!wbusy_reg[scan_reg[WIDX_W-1:0]])
                    begin
                        wbusy_next[scan_reg[WIDX_W-1:0]]  = 1'b1;
                        picked_next[scan_reg[WIDX_W-1:0]] = 1'b1;
                        claimed_next = claimed_reg + 1'b1;
                    end
                    scan_next = scan_reg + 1'b1;
                end
            ST_SLOT:
                if (sscan_reg >= (SIDX_W+1)'(TASK_SLOTS))
                    wbusy_next = wbusy_reg & ~picked_reg;
                else if (!used_reg[sscan_reg[SIDX_W-1:0]])
                    slot_next = sscan_reg[SIDX_W-1:0];
                else
                    sscan_next = sscan_reg + 1'b1;
            ST_SLOT_CHK:
            begin
                used_next[slot_reg] = 1'b1;
                ram_we        = 1'b1;
                dreq.start    = 1'b1;
                dreq.dividend = items_reg;
                dreq.divisor  = CNT_W'(claimed_reg);
                scan_next     = '0;
            end
            ST_DIV2:
                if (!dbusy)
                    per_next = quo;
            ST_EMIT:
            begin
                // Walk workers in order, one slice a cycle for each picked worker
                if (picked_reg[scan_reg[WIDX_W-1:0]])
                begin
                    rv_next      = 1'b1;
                    kind_next    = KIND_SLICE;
                    widx_next    = WID_W'(scan_reg);
                    st_next      = pos_reg;
                    en_next      = (emitted_reg + 1'b1 == claimed_reg) ? items_reg
                                                                    : pos_reg + per_reg;
                    th_next      = TID_W'(slot_reg);
                    pos_next     = en_next;
                    emitted_next = emitted_reg + 1'b1;
                end
                scan_next = scan_reg + 1'b1;
            end
            ST_HANDLE:
            begin
                rv_next   = 1'b1;
                kind_next = KIND_HANDLE;
                th_next   = TID_W'(slot_reg);
                last_next = 1'b1;
            end
            ST_INLINE:
            begin
                rv_next   = 1'b1;
                kind_next = KIND_INLINE;
                en_next   = items_reg;
                last_next = 1'b1;
            end
            ST_DONE_RD:
                ram_raddr = SIDX_W'(wtask_reg[wid_reg[WIDX_W-1:0]]);
            ST_DONE_WR:
            begin
                ram_waddr = SIDX_W'(wtask_reg[wid_reg[WIDX_W-1:0]]);
                ram_wdata = (ram_rdata != '0) ? ram_rdata - 1'b1 : ram_rdata;
                if (dwork)
                begin
                    ram_we = 1'b1;
                    wbusy_next[wid_reg[WIDX_W-1:0]] = 1'b0;
                end
            end
            ST_POLL_RD:
                ram_raddr = SIDX_W'(tid_reg);
            ST_POLL_WR:
            begin
                rv_next   = 1'b1;
                kind_next = KIND_FINISH;
                th_next   = tid_reg;
                last_next = 1'b1;
                dn_next   = 1'b1;
                if (used_reg[SIDX_W'(tid_reg)])
                begin
                    if (ram_rdata == '0)
                        used_next[SIDX_W'(tid_reg)] = 1'b0;
                    else
                        dn_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= 7'd8;
            wbusy_reg  <= '0;
            used_reg   <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                active_reg <= cfg_wdata;
            wbusy_reg <= wbusy_next;
            used_reg  <= used_next;
            rv_reg    <= rv_next;
        end
    end

    // Payload and scan registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            items_reg <= item_count;
            minr_reg  <= min_range;
            wid_reg   <= worker_id;
            tid_reg   <= task_id;
        end
        if (state_reg == ST_SLOT_CHK)
        begin
            for (int i = 0; i < WORKERS; i++)
                if (picked_reg[i])
                    wtask_reg[i] <= TID_W'(slot_reg);
        end
        wanted_reg  <= wanted_next;
        claimed_reg <= claimed_next;
        picked_reg  <= picked_next;
        scan_reg    <= scan_next;
        sscan_reg   <= sscan_next;
        slot_reg    <= slot_next;
        per_reg     <= per_next;
        pos_reg     <= pos_next;
        emitted_reg <= emitted_next;
        kind_reg    <= kind_next;
        widx_reg    <= widx_next;
        st_reg      <= st_next;
        en_reg      <= en_next;
        th_reg      <= th_next;
        dn_reg      <= dn_next;
        last_reg    <= last_next;
    end

    assign result_valid = rv_reg;
    assign kind         = kind_reg;
    assign worker_index = widx_reg;
    assign slice_start  = st_reg;
    assign slice_end    = en_reg;
    assign task_handle  = th_reg;
    assign task_done    = dn_reg;
    assign last         = last_reg;

endmodule

[src/pfwd_div.sv]
// Shared restoring divider: one quotient bit per cycle.
module pfwd_div
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pfwd_pkg::div_req_t     req,
    output logic                   busy,
    output logic [30:0]            quotient
);
    import pfwd_pkg::*;

    localparam int STEP_W = $clog2(CNT_W + 1);

    logic [CNT_W-1:0]  quo_reg, quo_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [CNT_W:0]    trial;

    // Load on start; then shift in one dividend bit and try to subtract
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = '0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = STEP_W'(CNT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg[CNT_W-1:0], quo_reg[CNT_W-1]};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[CNT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[CNT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg | req.start;
    assign quotient = quo_reg;

endmodule

[src/pfwd_slot_ram.sv]
// Task slot table: outstanding slice count per slot, one port each way.
module pfwd_slot_ram
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [pfwd_pkg::SIDX_W-1:0] waddr,
    input  logic [6:0]                  wdata,
    input  logic [pfwd_pkg::SIDX_W-1:0] raddr,
    output logic [6:0]                  rdata
);
    import pfwd_pkg::*;

    logic [6:0] mem [TASK_SLOTS];
    logic [6:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[tb/tb_parallel_for_work_dispatcher.sv]
// Testbench for the parallel-for work dispatcher: directed and random commands, scoreboard check.
`timescale 1ns / 1ps

import pfwd_pkg::*;

// One dispatcher result beat
typedef struct {
    kind_t       kind;
    logic [5:0]  worker_index;
    logic [30:0] slice_start;
    logic [30:0] slice_end;
    logic [6:0]  task_handle;
    logic        task_done;
    logic        last;
} dispatch_beat_t;

class dispatch_scoreboard;
    logic [6:0]     active_workers;
    bit             worker_busy [WORKERS];
    logic [6:0]     worker_task [WORKERS];
    bit             slot_in_use [TASK_SLOTS];
    logic [6:0]     slices_left [TASK_SLOTS];
    dispatch_beat_t pending_beats [$];
    int             errors;

    function new();
        active_workers = 7'd8;
        errors = 0;
        foreach (worker_busy[i]) begin
            worker_busy[i] = 0;
            worker_task[i] = '0;
        end
        foreach (slot_in_use[i]) begin
            slot_in_use[i] = 0;
            slices_left[i] = '0;
        end
    endfunction

    function void push(kind_t k, int w, logic [30:0] s, logic [30:0] e, int th, bit d, bit l);
        dispatch_beat_t b;
        b.kind = k;
        b.worker_index = w[5:0];
        b.slice_start = s;
        b.slice_end = e;
        b.task_handle = th[6:0];
        b.task_done = d;
        b.last = l;
        pending_beats.push_back(b);
    endfunction

    // Enqueue: split the job across idle workers or run it inline
    function void enqueue_job(logic [30:0] items, logic [30:0] minr);
        int n;
        int wanted;
        int picked [$];
        int slot;
        logic [30:0] per;
        logic [30:0] pos;
        logic [30:0] stop;
        n = (active_workers > WORKERS) ? WORKERS : active_workers;
        if (n <= 1 || items == 0) begin
            push(KIND_INLINE, 0, 0, items, 0, 0, 1);
            return;
        end
        wanted = n;
        if (minr > 0 && wanted > items / minr)
            wanted = items / minr;
        if (wanted > items)
            wanted = items;
        if (wanted < 1)
            wanted = 1;
        for (int i = 0; i < n && picked.size() < wanted; i++)
            if (!worker_busy[i])
                picked.push_back(i);
        slot = -1;
        for (int s = 0; s < TASK_SLOTS; s++)
            if (!slot_in_use[s]) begin
                slot = s;
                break;
            end
        if (picked.size() == 0 || slot < 0) begin
            push(KIND_INLINE, 0, 0, items, 0, 0, 1);
            return;
        end
        slot_in_use[slot] = 1;
        slices_left[slot] = 7'(picked.size());
        per = 31'(items / picked.size());
        pos = 0;
        foreach (picked[i]) begin
            stop = (i == picked.size() - 1) ? items : pos + per;
            worker_busy[picked[i]] = 1;
            worker_task[picked[i]] = 7'(slot);
            push(KIND_SLICE, picked[i], pos, stop, slot, 0, 0);
            pos = stop;
        end
        push(KIND_HANDLE, 0, 0, 0, slot, 0, 1);
    endfunction

    // Note one accepted command beat
    function void note_command(action_t act, logic [30:0] items, logic [30:0] minr,
                               logic [5:0] wid, logic [6:0] tid);
        bit d;
        case (act)
            ACT_ENQUEUE: enqueue_job(items, minr);
            ACT_DONE: begin
                if (wid < WORKERS && worker_busy[wid]) begin
                    if (slices_left[worker_task[wid]] > 0)
                        slices_left[worker_task[wid]]--;
                    worker_busy[wid] = 0;
                end
            end
            ACT_POLL: begin
                d = 1;
                if (slot_in_use[tid]) begin
                    if (slices_left[tid] == 0)
                        slot_in_use[tid] = 0;
                    else
                        d = 0;
                end
                push(KIND_FINISH, 0, 0, 0, tid, d, 1);
            end
            default: ;
        endcase
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_result(dispatch_beat_t got);
        dispatch_beat_t exp_b;
        if (pending_beats.size() == 0) begin
            $display("%0t: unexpected result kind=%0d", $time, got.kind);
            errors++;
            return;
        end
        exp_b = pending_beats.pop_front();
        if (got.kind !== exp_b.kind) begin
            $display("%0t: kind exp %0d got %0d", $time, exp_b.kind, got.kind);
            errors++;
        end
        if (got.worker_index !== exp_b.worker_index) begin
            $display("%0t: worker_index exp %0d got %0d", $time,
                     exp_b.worker_index, got.worker_index);
            errors++;
        end
        if (got.slice_start !== exp_b.slice_start) begin
            $display("%0t: slice_start exp %0d got %0d", $time,
                     exp_b.slice_start, got.slice_start);
            errors++;
        end
        if (got.slice_end !== exp_b.slice_end) begin
            $display("%0t: slice_end exp %0d got %0d", $time,
                     exp_b.slice_end, got.slice_end);
            errors++;
        end
        if (got.task_handle !== exp_b.task_handle) begin
            $display("%0t: task_handle exp %0d got %0d", $time,
                     exp_b.task_handle, got.task_handle);
            errors++;
        end
        if (got.task_done !== exp_b.task_done) begin
            $display("%0t: task_done exp %0d got %0d", $time,
                     exp_b.task_done, got.task_done);
            errors++;
        end
        if (got.last !== exp_b.last) begin
            $display("%0t: last exp %0d got %0d", $time, exp_b.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb_parallel_for_work_dispatcher;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [30:0] item_count;
    logic [30:0] min_range;
    logic [5:0]  worker_id;
    logic [6:0]  task_id;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        result_valid;
    logic [1:0]  kind;
    logic [5:0]  worker_index;
    logic [30:0] slice_start;
    logic [30:0] slice_end;
    logic [6:0]  task_handle;
    logic        task_done;
    logic        last;

    dispatch_scoreboard sb;
    int cycles = 0;
    int burst_left;

    parallel_for_work_dispatcher dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .item_count(item_count), .min_range(min_range), .worker_id(worker_id),
        .task_id(task_id), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .kind(kind), .worker_index(worker_index),
        .slice_start(slice_start), .slice_end(slice_end), .task_handle(task_handle),
        .task_done(task_done), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sample result beats and count cycles
    always @(posedge clk)
    begin
        dispatch_beat_t b;
        cycles <= cycles + 1;
        if (rst_n && result_valid) begin
            b.kind = kind_t'(kind);
            b.worker_index = worker_index;
            b.slice_start = slice_start;
            b.slice_end = slice_end;
            b.task_handle = task_handle;
            b.task_done = task_done;
            b.last = last;
            sb.check_result(b);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Drive one command beat, holding until accepted; start drops only in a gap
    task automatic send_command(action_t act, logic [30:0] items, logic [30:0] minr,
                                logic [5:0] wid, logic [6:0] tid);
        bit taken;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 30);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        start <= 1'b1;
        action <= act;
        item_count <= items;
        min_range <= minr;
        worker_id <= wid;
        task_id <= tid;
        taken = 0;
        while (!taken) begin
            @(posedge clk);
            taken = !busy;
            if (taken)
                sb.note_command(act, items, minr, wid, tid);
            @(negedge clk);
        end
    endtask

    // Drop start, wait for all expected beats, then a latency margin
    task automatic drain();
        start <= 1'b0;
        while (sb.pending_beats.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_active(logic [6:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.active_workers = value;
    endtask

    function automatic logic [30:0] rand_count();
        case ($urandom_range(0, 5))
            0: return 31'($urandom_range(0, 3));
            1: return 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
            2: return 31'($urandom);
            default: return 31'($urandom_range(1, 100));
        endcase
    endfunction

    // Random commands: enqueue, finish slices, poll and no-op
    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_command(ACT_ENQUEUE, rand_count(),
                                         ($urandom_range(0, 2) == 0) ? 31'd0 : rand_count(),
                                         6'($urandom), 7'($urandom));
                4, 5, 6: send_command(ACT_DONE, 31'($urandom), 31'($urandom),
                                      ($urandom_range(0, 4) == 0) ? 6'($urandom)
                                                                 : 6'($urandom_range(0, 7)),
                                      7'($urandom));
                7, 8: send_command(ACT_POLL, 31'($urandom), 31'($urandom), 6'($urandom),
                                   7'($urandom_range(0, 7)));
                default: send_command(($urandom_range(0, 1) != 0) ? ACT_POLL : ACT_NONE,
                                      31'($urandom), 31'($urandom), 6'($urandom),
                                      7'($urandom));
            endcase
        end
    endtask

    initial
    begin
        sb = new();
        burst_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_NONE;
        item_count = '0;
        min_range = '0;
        worker_id = '0;
        task_id = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, inline cases, remainder slice, stale ops
        send_command(ACT_ENQUEUE, 31'd0, 31'd0, 6'd0, 7'd0);
        send_command(ACT_ENQUEUE, 31'd1, 31'd0, 6'd0, 7'd0);
        send_command(ACT_ENQUEUE, 31'd19, 31'd0, 6'd0, 7'd0);
        send_command(ACT_ENQUEUE, 31'd100, 31'd0, 6'd0, 7'd0);
        send_command(ACT_POLL, 31'd0, 31'd0, 6'd0, 7'd1);
        send_command(ACT_DONE, 31'd0, 31'd0, 6'd1, 7'd0);
        send_command(ACT_DONE, 31'd0, 31'd0, 6'd63, 7'd0);
        send_command(ACT_DONE, 31'd0, 31'd0, 6'd1, 7'd0);
        for (int w = 2; w < 8; w++)
            send_command(ACT_DONE, 31'd0, 31'd0, w[5:0], 7'd0);
        send_command(ACT_POLL, 31'd0, 31'd0, 6'd0, 7'd1);
        send_command(ACT_POLL, 31'd0, 31'd0, 6'd0, 7'd1);
        send_command(ACT_POLL, 31'd0, 31'd0, 6'd0, 7'd127);
        send_command(ACT_ENQUEUE, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 6'd0, 7'd0);
        send_command(ACT_ENQUEUE, 31'h7FFF_FFFF, 31'd1, 6'd63, 7'd127);
        send_command(ACT_ENQUEUE, 31'd50, 31'd10, 6'd0, 7'd0);
        send_command(ACT_NONE, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 6'd63, 7'd127);
        send_command(ACT_POLL, 31'd0, 31'd0, 6'd0, 7'd0);
        for (int w = 0; w < 8; w++)
            send_command(ACT_DONE, 31'd0, 31'd0, w[5:0], 7'd0);

        random_phase(40);
        write_active(7'd0);
        random_phase(10);
        write_active(7'd1);
        random_phase(10);
        write_active(7'd2);
        random_phase(30);
        write_active(7'd127);
        random_phase(30);
        write_active(7'd64);
        random_phase(20);
        write_active(7'd5);
        // Fill all task slots without freeing any, to hit the no-free-slot path;
        // worker 0 is freed before each job so every job claims a worker
        for (int i = 0; i < 132; i++) begin
            send_command(ACT_DONE, 31'd0, 31'd0, 6'd0, 7'd0);
            send_command(ACT_ENQUEUE, 31'd10, 31'd0, 6'd0, 7'd0);
        end
        for (int t = 0; t < 16; t++)
            send_command(ACT_POLL, 31'd0, 31'd0, 6'd0, t[6:0]);
        random_phase(20);

        drain();
        if (sb.errors == 0 && sb.pending_beats.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
